// ----- design/rcfh_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfh_pkg
// Shared constants, codes and types of the ray / cylinder / floor hit pipeline.
// ----------------------------------------------------------------------------
package rcfh_pkg;

    // Coordinate format.
    localparam int DATA_W        = 32;
    localparam int RADIUS_W      = 31;
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd5;

    // Result kinds.
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_MISS     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WALL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FLOOR    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOL      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PARALLEL = 3'd4;

    // Internal widths.
    localparam int MAG_W  = 32;   // magnitude of a coordinate difference
    localparam int LIN_W  = 65;   // Bh, K and A
    localparam int WIDE_W = 128;  // A*R^2, K^2 and the discriminant
    localparam int ROOT_W = WIDE_W / 2;
    localparam int NMAG_W = 66;   // magnitude of N = s - Bh
    localparam int PW_W   = NMAG_W + MAG_W;  // wall dividend
    localparam int PF_W   = 2 * MAG_W;       // floor dividend

    // Quotients are capped at 2^40.
    localparam int Q_W = 41;
    localparam logic [Q_W-1:0] QCAP = {1'b1, {(Q_W-1){1'b0}}};

    // Saturating offset add.
    localparam int SUM_W = Q_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

    // Pipeline latencies.
    localparam int SQRT_LAT = ROOT_W + 1;
    localparam int DIV_LAT  = Q_W + 1;
    localparam int PIPE_LAT = 7 + SQRT_LAT + 3 + DIV_LAT + 2;

    // Ray geometry carried alongside the square root.
    typedef struct packed {
        logic              last;
        logic              sgn_x;
        logic              sgn_y;
        logic              sgn_z;
        logic [MAG_W-1:0]  mdx;
        logic [MAG_W-1:0]  mdy;
        logic [MAG_W-1:0]  mdz;
        logic [LIN_W-1:0]  bh;
        logic [LIN_W-1:0]  a;
    } geo_t;

    // Side information carried alongside the dividers.
    typedef struct packed {
        logic       last;
        logic       hit;
        logic       dy_zero;
        logic [2:0] wneg;
        logic [1:0] fneg;
    } side_t;

endpackage

// ----- design/ray_cylinder_floor_hit.sv -----
// ----------------------------------------------------------------------------
// ray_cylinder_floor_hit
// Lidar ray against a cylinder wall about the z axis, with floor projection.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid/s_ready) takes one ray endpoint per transaction;
// the ray starts at the configured sensor origin. The result channel
// (m_valid/m_ready) gives exactly one hit point per ray, in order, with its
// kind code and the copied last flag.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// while no ray is in flight; unknown indexes are ignored.
// A new ray is taken every cycle unless a held result stalls the pipeline.
// Each ray passes through the 65-stage square root (one root bit per stage),
// the 42-stage dividers (one quotient bit per stage) and 12 stages of
// products, sums and result selection.
// When the receiver stalls a valid result, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and restores the
// registers: origin zero, radius 1.0, floor 0, tolerance 0.001.
// ----------------------------------------------------------------------------
module ray_cylinder_floor_hit #(
    parameter int FRAC_BITS = rcfh_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rcfh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcfh_pkg::DATA_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rcfh_pkg::DATA_W-1:0]  s_end_x,
    input  logic signed [rcfh_pkg::DATA_W-1:0]  s_end_y,
    input  logic signed [rcfh_pkg::DATA_W-1:0]  s_end_z,
    input  logic                                s_last_ray,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rcfh_pkg::DATA_W-1:0]  m_hit_x,
    output logic signed [rcfh_pkg::DATA_W-1:0]  m_hit_y,
    output logic signed [rcfh_pkg::DATA_W-1:0]  m_hit_z,
    output logic [rcfh_pkg::KIND_W-1:0]         m_hit_kind,
    output logic                                m_last_out
);
    import rcfh_pkg::*;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1) << FRAC_BITS;
    localparam int                  TOL_INT    = ((1 << FRAC_BITS) + 500) / 1000;
    localparam logic [DATA_W-1:0]   TOL_RST    = DATA_W'(TOL_INT);

    // Configuration registers.
    logic signed [DATA_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [DATA_W-1:0] floor_reg, tol_reg;
    logic [RADIUS_W-1:0]      radius_reg;

    // Pipeline control.
    logic                     en;
    logic [PIPE_LAT-1:0]      vld_reg;

    // P1: differences.
    logic signed [DATA_W:0]   dx_p1_reg, dy_p1_reg, dz_p1_reg;
    logic                     last_p1_reg;

    // P2: products.
    logic [MAG_W-1:0]         mdx_c, mdy_c, mdz_c;
    logic [MAG_W-1:0]         mdx_p2_reg, mdy_p2_reg, mdz_p2_reg;
    logic                     sx_p2_reg, sy_p2_reg, sz_p2_reg, last_p2_reg;
    logic [62:0]              px_c, py_c, px_p2_reg, py_p2_reg;
    logic signed [63:0]       kxa_c, kyb_c, bx_c, by_c;
    logic signed [63:0]       kxa_p2_reg, kyb_p2_reg, bx_p2_reg, by_p2_reg;
    logic [63:0]              ax_c, ay_c, ax_p2_reg, ay_p2_reg;

    // P3..P7.
    geo_t                     geo_pre_reg [0:4];
    logic signed [LIN_W-1:0]  k_p3_reg;
    logic [63:0]              pxll_p3_reg, pyll_p3_reg;
    logic [62:0]              pxlh_p3_reg, pylh_p3_reg;
    logic [61:0]              pxhh_p3_reg, pyhh_p3_reg;
    logic [LIN_W-1:0]         kabs_c;
    logic [WIDE_W-1:0]        ar2_p4_reg, ar2_p5_reg, ar2_p6_reg;
    logic [63:0]              km_p4_reg;
    logic [63:0]              kll_p5_reg, klh_p5_reg, khh_p5_reg;
    logic [WIDE_W-1:0]        k2_p6_reg;
    logic                     hit_p7_reg;
    logic [WIDE_W-1:0]        disc_p7_reg;

    // Square-root span.
    logic [ROOT_W-1:0]        root;
    geo_t                     geo_line_reg [0:SQRT_LAT-1];
    logic                     hit_line_reg [0:SQRT_LAT-1];
    geo_t                     geo_s;

    // Q1: N and the floor numerator.
    logic signed [NMAG_W:0]   n_c;
    logic signed [DATA_W:0]   num_c;
    logic [NMAG_W-1:0]        nmag_q1_reg;
    logic                     nneg_q1_reg, hit_q1_reg, numneg_q1_reg;
    logic [MAG_W-1:0]         mnum_q1_reg;
    geo_t                     geo_q1_reg;

    // Q2: partial products.
    logic [MAG_W-1:0]         mc [0:2];
    logic [63:0]              pp0_q2_reg [0:2];
    logic [63:0]              pp1_q2_reg [0:2];
    logic [MAG_W+1:0]         pp2_q2_reg [0:2];
    logic [PF_W-1:0]          fp_q2_reg  [0:1];
    logic [LIN_W-1:0]         a_q2_reg;
    logic [MAG_W-1:0]         mdy_q2_reg;
    side_t                    side_q2_reg;

    // Q3: dividends.
    logic [PW_W-1:0]          p_q3_reg  [0:2];
    logic [PF_W-1:0]          fp_q3_reg [0:1];
    logic [LIN_W-1:0]         a_q3_reg;
    logic [MAG_W-1:0]         mdy_q3_reg;
    side_t                    side_q3_reg;

    // Divider span.
    logic [Q_W-1:0]           wq [0:2];
    logic [Q_W-1:0]           fq [0:1];
    side_t                    side_line_reg [0:DIV_LAT-1];
    side_t                    side_d;

    // R1: saturated coordinates.
    logic [DATA_W-1:0]        wx_r1_reg, wy_r1_reg, wz_r1_reg, fx_r1_reg, fz_r1_reg;
    side_t                    side_r1_reg;

    // R2: result register.
    logic [DATA_W-1:0]        hit_x_reg, hit_y_reg, hit_z_reg;
    logic [DATA_W-1:0]        hit_x_next, hit_y_next, hit_z_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic                     last_out_reg;
    logic signed [DATA_W:0]   gap_c;

    // Origin plus or minus a capped quotient, saturated to 32 bits.
    function automatic logic [DATA_W-1:0] sat_offset(
        input logic signed [DATA_W-1:0] org,
        input logic [Q_W-1:0]           q,
        input logic                     neg
    );
        logic signed [SUM_W-1:0] sum;
        sum = neg ? SUM_W'(org) - $signed({2'b00, q}) : SUM_W'(org) + $signed({2'b00, q});
        if (sum > SAT_HI) begin
            return SAT_HI[DATA_W-1:0];
        end else if (sum < SAT_LO) begin
            return SAT_LO[DATA_W-1:0];
        end
        return sum[DATA_W-1:0];
    endfunction

    // The whole pipeline advances unless a finished result is held back.
    assign en      = !vld_reg[PIPE_LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE_LAT-1];

    // Valid bits and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            radius_reg   <= RADIUS_RST;
            floor_reg    <= '0;
            tol_reg      <= TOL_RST;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ORIGIN_X:  origin_x_reg <= cfg_wdata;
                    CFG_ORIGIN_Y:  origin_y_reg <= cfg_wdata;
                    CFG_ORIGIN_Z:  origin_z_reg <= cfg_wdata;
                    CFG_RADIUS:    radius_reg   <= cfg_wdata[RADIUS_W-1:0];
                    CFG_FLOOR:     floor_reg    <= cfg_wdata;
                    CFG_TOLERANCE: tol_reg      <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Magnitudes and single products of the ray direction.
    assign mdx_c  = dx_p1_reg[DATA_W] ? MAG_W'(-dx_p1_reg) : MAG_W'(dx_p1_reg);
    assign mdy_c  = dy_p1_reg[DATA_W] ? MAG_W'(-dy_p1_reg) : MAG_W'(dy_p1_reg);
    assign mdz_c  = dz_p1_reg[DATA_W] ? MAG_W'(-dz_p1_reg) : MAG_W'(dz_p1_reg);
    assign px_c   = mdx_c * radius_reg;
    assign py_c   = mdy_c * radius_reg;
    assign kxa_c  = origin_x_reg * dy_p1_reg;
    assign kyb_c  = origin_y_reg * dx_p1_reg;
    assign bx_c   = origin_x_reg * dx_p1_reg;
    assign by_c   = origin_y_reg * dy_p1_reg;
    assign ax_c   = mdx_c * mdx_c;
    assign ay_c   = mdy_c * mdy_c;
    assign kabs_c = k_p3_reg[LIN_W-1] ? LIN_W'(-k_p3_reg) : LIN_W'(k_p3_reg);

    // Signed N = s - Bh and the floor numerator h - oy.
    assign geo_s = geo_line_reg[SQRT_LAT-1];
    assign n_c   = $signed({3'b000, root}) - $signed({{2{geo_s.bh[LIN_W-1]}}, geo_s.bh});
    assign num_c = $signed({floor_reg[DATA_W-1], floor_reg})
                 - $signed({origin_y_reg[DATA_W-1], origin_y_reg});

    assign mc[0] = geo_q1_reg.mdx;
    assign mc[1] = geo_q1_reg.mdy;
    assign mc[2] = geo_q1_reg.mdz;

    // Front of the pipeline up to the discriminant.
    always_ff @(posedge aclk) begin
        if (en) begin
            // P1
            dx_p1_reg   <= $signed({s_end_x[DATA_W-1], s_end_x})
                         - $signed({origin_x_reg[DATA_W-1], origin_x_reg});
            dy_p1_reg   <= $signed({s_end_y[DATA_W-1], s_end_y})
                         - $signed({origin_y_reg[DATA_W-1], origin_y_reg});
            dz_p1_reg   <= $signed({s_end_z[DATA_W-1], s_end_z})
                         - $signed({origin_z_reg[DATA_W-1], origin_z_reg});
            last_p1_reg <= s_last_ray;
            // P2
            mdx_p2_reg  <= mdx_c;
            mdy_p2_reg  <= mdy_c;
            mdz_p2_reg  <= mdz_c;
            sx_p2_reg   <= dx_p1_reg[DATA_W];
            sy_p2_reg   <= dy_p1_reg[DATA_W];
            sz_p2_reg   <= dz_p1_reg[DATA_W];
            last_p2_reg <= last_p1_reg;
            px_p2_reg   <= px_c;
            py_p2_reg   <= py_c;
            kxa_p2_reg  <= kxa_c;
            kyb_p2_reg  <= kyb_c;
            bx_p2_reg   <= bx_c;
            by_p2_reg   <= by_c;
            ax_p2_reg   <= ax_c;
            ay_p2_reg   <= ay_c;
            // P3: linear terms and the partial squares of |d|*R
            geo_pre_reg[0].last  <= last_p2_reg;
            geo_pre_reg[0].sgn_x <= sx_p2_reg;
            geo_pre_reg[0].sgn_y <= sy_p2_reg;
            geo_pre_reg[0].sgn_z <= sz_p2_reg;
            geo_pre_reg[0].mdx   <= mdx_p2_reg;
            geo_pre_reg[0].mdy   <= mdy_p2_reg;
            geo_pre_reg[0].mdz   <= mdz_p2_reg;
            geo_pre_reg[0].bh    <= LIN_W'(LIN_W'(bx_p2_reg) + LIN_W'(by_p2_reg));
            geo_pre_reg[0].a     <= LIN_W'(ax_p2_reg) + LIN_W'(ay_p2_reg);
            k_p3_reg    <= LIN_W'(kxa_p2_reg) - LIN_W'(kyb_p2_reg);
            pxll_p3_reg <= px_p2_reg[31:0] * px_p2_reg[31:0];
            pxlh_p3_reg <= px_p2_reg[31:0] * px_p2_reg[62:32];
            pxhh_p3_reg <= px_p2_reg[62:32] * px_p2_reg[62:32];
            pyll_p3_reg <= py_p2_reg[31:0] * py_p2_reg[31:0];
            pylh_p3_reg <= py_p2_reg[31:0] * py_p2_reg[62:32];
            pyhh_p3_reg <= py_p2_reg[62:32] * py_p2_reg[62:32];
            // P4: A*R^2 and the low 64 bits of |K|
            for (int i = 0; i < 4; i++) begin
                geo_pre_reg[i+1] <= geo_pre_reg[i];
            end
            ar2_p4_reg <= WIDE_W'(pxll_p3_reg) + (WIDE_W'(pxlh_p3_reg) << 33)
                        + (WIDE_W'(pxhh_p3_reg) << 64)
                        + WIDE_W'(pyll_p3_reg) + (WIDE_W'(pylh_p3_reg) << 33)
                        + (WIDE_W'(pyhh_p3_reg) << 64);
            km_p4_reg  <= kabs_c[63:0];
            // P5: partial squares of |K|
            ar2_p5_reg <= ar2_p4_reg;
            kll_p5_reg <= km_p4_reg[31:0] * km_p4_reg[31:0];
            klh_p5_reg <= km_p4_reg[31:0] * km_p4_reg[63:32];
            khh_p5_reg <= km_p4_reg[63:32] * km_p4_reg[63:32];
            // P6: K^2
            ar2_p6_reg <= ar2_p5_reg;
            k2_p6_reg  <= WIDE_W'(kll_p5_reg) + (WIDE_W'(klh_p5_reg) << 33)
                        + (WIDE_W'(khh_p5_reg) << 64);
            // P7: discriminant and the hit test
            hit_p7_reg  <= ar2_p6_reg > k2_p6_reg;
            disc_p7_reg <= ar2_p6_reg - k2_p6_reg;
        end
    end

    rcfh_sqrt #(
        .IN_W (WIDE_W)
    ) u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (disc_p7_reg),
        .root     (root)
    );

    // Middle of the pipeline: N, its products with the direction, dividends.
    always_ff @(posedge aclk) begin
        if (en) begin
            geo_line_reg[0] <= geo_pre_reg[4];
            hit_line_reg[0] <= hit_p7_reg;
            for (int i = 0; i < SQRT_LAT - 1; i++) begin
                geo_line_reg[i+1] <= geo_line_reg[i];
                hit_line_reg[i+1] <= hit_line_reg[i];
            end
            // Q1
            nneg_q1_reg   <= n_c[NMAG_W];
            nmag_q1_reg   <= n_c[NMAG_W] ? NMAG_W'(-n_c) : NMAG_W'(n_c);
            hit_q1_reg    <= hit_line_reg[SQRT_LAT-1];
            geo_q1_reg    <= geo_s;
            numneg_q1_reg <= num_c[DATA_W];
            mnum_q1_reg   <= num_c[DATA_W] ? MAG_W'(-num_c) : MAG_W'(num_c);
            // Q2
            for (int i = 0; i < 3; i++) begin
                pp0_q2_reg[i] <= nmag_q1_reg[31:0] * mc[i];
                pp1_q2_reg[i] <= nmag_q1_reg[63:32] * mc[i];
                pp2_q2_reg[i] <= nmag_q1_reg[NMAG_W-1:64] * mc[i];
            end
            fp_q2_reg[0]        <= geo_q1_reg.mdx * mnum_q1_reg;
            fp_q2_reg[1]        <= geo_q1_reg.mdz * mnum_q1_reg;
            a_q2_reg            <= geo_q1_reg.a;
            mdy_q2_reg          <= geo_q1_reg.mdy;
            side_q2_reg.last    <= geo_q1_reg.last;
            side_q2_reg.hit     <= hit_q1_reg;
            side_q2_reg.dy_zero <= geo_q1_reg.mdy == '0;
            side_q2_reg.wneg    <= {nneg_q1_reg ^ geo_q1_reg.sgn_z,
                                    nneg_q1_reg ^ geo_q1_reg.sgn_y,
                                    nneg_q1_reg ^ geo_q1_reg.sgn_x};
            side_q2_reg.fneg    <= {geo_q1_reg.sgn_z ^ numneg_q1_reg ^ geo_q1_reg.sgn_y,
                                    geo_q1_reg.sgn_x ^ numneg_q1_reg ^ geo_q1_reg.sgn_y};
            // Q3
            for (int i = 0; i < 3; i++) begin
                p_q3_reg[i] <= PW_W'(pp0_q2_reg[i]) + (PW_W'(pp1_q2_reg[i]) << 32)
                             + (PW_W'(pp2_q2_reg[i]) << 64);
            end
            fp_q3_reg[0] <= fp_q2_reg[0];
            fp_q3_reg[1] <= fp_q2_reg[1];
            a_q3_reg     <= a_q2_reg;
            mdy_q3_reg   <= mdy_q2_reg;
            side_q3_reg  <= side_q2_reg;
        end
    end

    // Wall dividers, x y z: |N|*|d| / A.
    for (genvar g = 0; g < 3; g++) begin : g_wall_div
        rcfh_div #(
            .NUM_W (PW_W),
            .DEN_W (LIN_W)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (p_q3_reg[g]),
            .den  (a_q3_reg),
            .quot (wq[g])
        );
    end

    // Floor dividers, x z: |d|*|h - oy| / |dy|.
    for (genvar g = 0; g < 2; g++) begin : g_floor_div
        rcfh_div #(
            .NUM_W (PF_W),
            .DEN_W (MAG_W)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (fp_q3_reg[g]),
            .den  (mdy_q3_reg),
            .quot (fq[g])
        );
    end

    assign side_d = side_line_reg[DIV_LAT-1];

    // Below-floor gap of the wall hit.
    assign gap_c = $signed({wy_r1_reg[DATA_W-1], wy_r1_reg})
                 - $signed({floor_reg[DATA_W-1], floor_reg});

    // Result selection.
    always_comb begin
        kind_next  = KIND_MISS;
        hit_x_next = '0;
        hit_y_next = '0;
        hit_z_next = '0;
        if (!side_r1_reg.hit) begin
            kind_next = KIND_MISS;
        end else if ($signed(wy_r1_reg) >= floor_reg) begin
            kind_next  = KIND_WALL;
            hit_x_next = wx_r1_reg;
            hit_y_next = wy_r1_reg;
            hit_z_next = wz_r1_reg;
        end else if (gap_c < $signed({tol_reg[DATA_W-1], tol_reg})) begin
            if (side_r1_reg.dy_zero) begin
                kind_next = KIND_PARALLEL;
            end else begin
                kind_next  = KIND_FLOOR;
                hit_x_next = fx_r1_reg;
                hit_y_next = floor_reg;
                hit_z_next = fz_r1_reg;
            end
        end else begin
            kind_next = KIND_TOL;
        end
    end

    // Back of the pipeline: saturation and the result register.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_line_reg[0] <= side_q3_reg;
            for (int i = 0; i < DIV_LAT - 1; i++) begin
                side_line_reg[i+1] <= side_line_reg[i];
            end
            // R1
            wx_r1_reg   <= sat_offset(origin_x_reg, wq[0], side_d.wneg[0]);
            wy_r1_reg   <= sat_offset(origin_y_reg, wq[1], side_d.wneg[1]);
            wz_r1_reg   <= sat_offset(origin_z_reg, wq[2], side_d.wneg[2]);
            fx_r1_reg   <= sat_offset(origin_x_reg, fq[0], side_d.fneg[0]);
            fz_r1_reg   <= sat_offset(origin_z_reg, fq[1], side_d.fneg[1]);
            side_r1_reg <= side_d;
            // R2
            hit_x_reg    <= hit_x_next;
            hit_y_reg    <= hit_y_next;
            hit_z_reg    <= hit_z_next;
            kind_reg     <= kind_next;
            last_out_reg <= side_r1_reg.last;
        end
    end

    assign m_hit_x    = hit_x_reg;
    assign m_hit_y    = hit_y_reg;
    assign m_hit_z    = hit_z_reg;
    assign m_hit_kind = kind_reg;
    assign m_last_out = last_out_reg;

    // A miss carries no point.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_hit_kind == KIND_MISS) |->
            (m_hit_x == '0) && (m_hit_y == '0) && (m_hit_z == '0))
        else $error("miss result with a nonzero point");

    // A floor point lies on the floor plane.
    a_floor_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_hit_kind == KIND_FLOOR) |-> (m_hit_y == floor_reg))
        else $error("floor result off the floor plane");

    // A wall point is at or above the floor.
    a_wall_above: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_hit_kind == KIND_WALL) |-> (m_hit_y >= floor_reg))
        else $error("wall result below the floor");

    // A stalled result keeps the input side closed.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while the pipeline is held");

endmodule

// ----- design/rcfh_sqrt.sv -----
// ----------------------------------------------------------------------------
// rcfh_sqrt
// Pipelined integer square root, one result bit per stage, floor of the root.
// ----------------------------------------------------------------------------
module rcfh_sqrt #(
    parameter int IN_W = rcfh_pkg::WIDE_W
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [IN_W-1:0]       radicand,
    output logic [IN_W/2-1:0]     root
);
    import rcfh_pkg::*;

    localparam int RW    = IN_W / 2;
    localparam int REM_W = RW + 3;

    logic [REM_W-1:0] rem_reg  [0:RW-1];
    logic [RW-1:0]    root_reg [0:RW];
    logic [IN_W-1:0]  dlo_reg  [0:RW-1];

    logic [REM_W-1:0] rem_next  [0:RW-1];
    logic [RW-1:0]    root_next [0:RW-1];

    // One restoring step per stage: bring down two radicand bits, try 4r+1.
    always_comb begin
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        for (int i = 0; i < RW; i++) begin
            shifted = {rem_reg[i][REM_W-3:0], dlo_reg[i][IN_W-1:IN_W-2]};
            trial   = {1'b0, root_reg[i], 2'b01};
            if (shifted >= trial) begin
                rem_next[i]  = shifted - trial;
                root_next[i] = {root_reg[i][RW-2:0], 1'b1};
            end else begin
                rem_next[i]  = shifted;
                root_next[i] = {root_reg[i][RW-2:0], 1'b0};
            end
        end
    end

    // Stage registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            dlo_reg[0]  <= radicand;
            for (int i = 0; i < RW - 1; i++) begin
                rem_reg[i+1] <= rem_next[i];
                dlo_reg[i+1] <= dlo_reg[i] << 2;
            end
            for (int i = 0; i < RW; i++) begin
                root_reg[i+1] <= root_next[i];
            end
        end
    end

    assign root = root_reg[RW];

endmodule

// ----- design/rcfh_div.sv -----
// ----------------------------------------------------------------------------
// rcfh_div
// Pipelined restoring divider with a quotient capped at 2^40.
// ----------------------------------------------------------------------------
module rcfh_div #(
    parameter int NUM_W = rcfh_pkg::PW_W,
    parameter int DEN_W = rcfh_pkg::LIN_W
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [NUM_W-1:0]       num,
    input  logic [DEN_W-1:0]       den,
    output logic [rcfh_pkg::Q_W-1:0] quot
);
    import rcfh_pkg::*;

    localparam int TW = NUM_W - Q_W;
    localparam int RW = DEN_W + 1;
    localparam int MW = (TW > DEN_W) ? TW : DEN_W;

    logic [RW-1:0]    r_reg   [0:Q_W-1];
    logic [Q_W-1:0]   lo_reg  [0:Q_W-1];
    logic [DEN_W-1:0] den_reg [0:Q_W-1];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             ovf_reg [0:Q_W];

    logic [RW-1:0]    r_next [0:Q_W-1];
    logic [Q_W-1:0]   q_next [0:Q_W-1];
    logic [TW-1:0]    top;

    // The upper dividend part already at or above the divisor means q >= 2^41.
    assign top = num[NUM_W-1:Q_W];

    // One quotient bit per stage.
    always_comb begin
        logic [RW-1:0] shifted;
        logic          take;
        for (int i = 0; i < Q_W; i++) begin
            shifted   = {r_reg[i][RW-2:0], lo_reg[i][Q_W-1]};
            take      = shifted >= RW'(den_reg[i]);
            r_next[i] = take ? shifted - RW'(den_reg[i]) : shifted;
            q_next[i] = {q_reg[i][Q_W-2:0], take};
        end
    end

    // Stage registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= RW'(top);
            lo_reg[0]  <= num[Q_W-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= MW'(top) >= MW'(den);
            for (int i = 0; i < Q_W - 1; i++) begin
                r_reg[i+1]   <= r_next[i];
                lo_reg[i+1]  <= lo_reg[i] << 1;
                den_reg[i+1] <= den_reg[i];
            end
            for (int i = 0; i < Q_W; i++) begin
                q_reg[i+1]   <= q_next[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    assign quot = (ovf_reg[Q_W] || (q_reg[Q_W] > QCAP)) ? QCAP : q_reg[Q_W];

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ray / cylinder wall / floor hit pipeline.
// A directed table covers the obvious cases: misses, axis rays, floor
// projection, the tolerance and parallel-ray codes, and extreme coordinates
// and registers. It is followed by random phases, each with its own register
// setting. Each result is checked against its typed point or a bit-exact hit-point calculator.
// ----------------------------------------------------------------------------
module testbench;
    import rcfh_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int WD_LIMIT    = 4000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_RAYS  = 325;
    localparam logic [63:0] Q_CAP = 64'd1 << 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic [KIND_W-1:0]        kind;
        logic                     last;
    } hit_t;

    typedef struct packed {
        logic [DATA_W-1:0] ox;
        logic [DATA_W-1:0] oy;
        logic [DATA_W-1:0] oz;
        logic [DATA_W-1:0] rad;
        logic [DATA_W-1:0] flr;
        logic [DATA_W-1:0] tol;
    } setting_t;

    typedef struct packed {
        logic [2:0]               sel;
        logic signed [DATA_W-1:0] ex;
        logic signed [DATA_W-1:0] ey;
        logic signed [DATA_W-1:0] ez;
        logic                     last;
        logic                     typed;
        logic signed [DATA_W-1:0] kx;
        logic signed [DATA_W-1:0] ky;
        logic signed [DATA_W-1:0] kz;
        logic [KIND_W-1:0]        kk;
    } ray_row_t;

    localparam logic [31:0] MAXV = 32'h7fffffff;
    localparam logic [31:0] MINV = 32'h80000000;

    // Register settings used by the directed table. Setting 0 is the reset state.
    setting_t dir_settings [5] = '{
        '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd66},
        '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd10, 32'd66},
        '{32'd0, 32'd0, 32'd0, 32'd65536, 32'd10, -32'sd100},
        '{MINV, MAXV, MINV, 32'hffffffff, MINV, MAXV},
        '{MAXV, MINV, MAXV, 32'd0, MAXV, MINV}
    };

    // Directed rays. Rows with typed set carry their own expected point.
    ray_row_t dir_rows [20] = '{
        '{3'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd0, 32'd0, 32'd0, 32'd327680, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd0, 32'd131072, 32'd0, 32'd0, 1'b0, 1'b1, 32'd65536, 32'd0, 32'd0, KIND_WALL},
        '{3'd0, 32'd0, 32'd131072, 32'd7, 1'b1, 1'b1, 32'd0, 32'd65536, 32'd3, KIND_WALL},
        '{3'd0, 32'd0, -32'sd131072, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, KIND_FLOOR},
        '{3'd0, -32'sd131072, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd0, MAXV, MAXV, MAXV, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd0, MINV, MINV, MINV, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd0, MAXV, MINV, 32'd0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd0, MINV, MAXV, 32'hffffffff, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd0, 32'd1, -32'sd1, 32'h55555555, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd1, 32'd131072, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, KIND_PARALLEL},
        '{3'd1, 32'd0, -32'sd131072, 32'd131072, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd2, 32'd131072, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, KIND_TOL},
        '{3'd3, MAXV, MAXV, MAXV, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd3, MINV, MINV, MINV, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd3, MAXV, MINV, 32'haaaaaaaa, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd3, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd4, 32'd131072, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, KIND_MISS},
        '{3'd4, MAXV, MINV, MAXV, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0, KIND_MISS}
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_end_x;
    logic signed [DATA_W-1:0] s_end_y;
    logic signed [DATA_W-1:0] s_end_z;
    logic                     s_last_ray;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_hit_x;
    logic signed [DATA_W-1:0] m_hit_y;
    logic signed [DATA_W-1:0] m_hit_z;
    logic [KIND_W-1:0]        m_hit_kind;
    logic                     m_last_out;

    // Register copy kept by the bench.
    logic signed [DATA_W-1:0] reg_ox, reg_oy, reg_oz, reg_floor, reg_tol;
    logic [RADIUS_W-1:0]      reg_radius;

    hit_t pending_hits[$];
    int   error_count;
    int   idle_cycles;
    int   burst_left;
    int   rx_cycle;
    int   rx_mode;

    ray_cylinder_floor_hit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .s_end_z    (s_end_z),
        .s_last_ray (s_last_ray),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit_x    (m_hit_x),
        .m_hit_y    (m_hit_y),
        .m_hit_z    (m_hit_z),
        .m_hit_kind (m_hit_kind),
        .m_last_out (m_last_out)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > longint'(MAXV)) return longint'(MAXV);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Floor of the square root of a 128-bit value, one bit at a time.
    function automatic logic [63:0] root_floor(logic [127:0] d);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (({64'd0, c} * {64'd0, c}) <= d) r = c;
        end
        return r;
    endfunction

    // Offset plus truncated, capped dc*N/A along the wall solution.
    function automatic longint wall_axis(longint o, longint dc, logic signed [127:0] n,
                                         logic [127:0] a);
        logic [127:0] nm;
        logic [127:0] p;
        logic [127:0] q;
        logic         neg;
        nm = n[127] ? 128'(-n) : 128'(n);
        p = nm * {64'd0, magnitude(dc)};
        if (a == 0) q = {64'd0, Q_CAP};
        else q = p / a;
        if (q > {64'd0, Q_CAP}) q = {64'd0, Q_CAP};
        neg = n[127] != (dc < 0);
        return clamp32(neg ? o - longint'(q[63:0]) : o + longint'(q[63:0]));
    endfunction

    // Offset plus truncated, capped dc*num/den along the floor plane.
    function automatic longint floor_axis(longint o, longint dc, longint num, longint den);
        logic [63:0] q;
        logic        neg;
        q = (magnitude(dc) * magnitude(num)) / magnitude(den);
        if (q > Q_CAP) q = Q_CAP;
        neg = (dc < 0) != ((num < 0) != (den < 0));
        if (dc == 0 || num == 0) neg = 1'b0;
        return clamp32(neg ? o - longint'(q) : o + longint'(q));
    endfunction

    // Expected hit point of one ray under the current register copy.
    function automatic hit_t predict_hit(logic signed [31:0] ex, logic signed [31:0] ey,
                                         logic signed [31:0] ez, logic last);
        longint              ox, oy, oz, h, dx, dy, dz, wy, num;
        logic [63:0]         px, py;
        logic signed [127:0] w_ox, w_oy, w_dx, w_dy, kprod, bh, n;
        logic [127:0]        ar2, k2, cm, disc, a;
        hit_t                r;
        ox = reg_ox;
        oy = reg_oy;
        oz = reg_oz;
        h = reg_floor;
        dx = longint'(ex) - ox;
        dy = longint'(ey) - oy;
        dz = longint'(ez) - oz;
        r = '0;
        r.kind = KIND_MISS;
        r.last = last;
        px = magnitude(dx) * {33'd0, reg_radius};
        py = magnitude(dy) * {33'd0, reg_radius};
        ar2 = {64'd0, px} * {64'd0, px} + {64'd0, py} * {64'd0, py};
        w_ox = ox;
        w_oy = oy;
        w_dx = dx;
        w_dy = dy;
        kprod = w_ox * w_dy - w_oy * w_dx;
        cm = kprod[127] ? 128'(-kprod) : 128'(kprod);
        k2 = {64'd0, cm[63:0]} * {64'd0, cm[63:0]};
        if (ar2 > k2) begin
            disc = ar2 - k2;
            bh = w_ox * w_dx + w_oy * w_dy;
            a = 128'(w_dx * w_dx + w_dy * w_dy);
            n = $signed({64'd0, root_floor(disc)}) - bh;
            wy = wall_axis(oy, dy, n, a);
            if (wy >= h) begin
                r.kind = KIND_WALL;
                r.x = 32'(wall_axis(ox, dx, n, a));
                r.y = 32'(wy);
                r.z = 32'(wall_axis(oz, dz, n, a));
            end else if (wy - h < longint'(reg_tol)) begin
                if (dy == 0) begin
                    r.kind = KIND_PARALLEL;
                end else begin
                    num = h - oy;
                    r.kind = KIND_FLOOR;
                    r.x = 32'(floor_axis(ox, dx, num, dy));
                    r.y = 32'(h);
                    r.z = 32'(floor_axis(oz, dz, num, dy));
                end
            end else begin
                r.kind = KIND_TOL;
            end
        end
        return r;
    endfunction

    // Present one ray and hold it until the transaction completes.
    task automatic send_ray(logic signed [31:0] ex, logic signed [31:0] ey,
                            logic signed [31:0] ez, logic last, logic typed, hit_t typed_hit);
        s_valid <= 1'b1;
        s_end_x <= ex;
        s_end_y <= ey;
        s_end_z <= ez;
        s_last_ray <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_hits.push_back(typed ? typed_hit : predict_hit(ex, ey, ez, last));
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
        end
    endtask

    // Stop sending and wait until the pipeline is empty.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_ORIGIN_X:  reg_ox = data;
            CFG_ORIGIN_Y:  reg_oy = data;
            CFG_ORIGIN_Z:  reg_oz = data;
            CFG_RADIUS:    reg_radius = data[RADIUS_W-1:0];
            CFG_FLOOR:     reg_floor = data;
            CFG_TOLERANCE: reg_tol = data;
            default: ;
        endcase
    endtask

    // Write a full register setting, plus writes to unused indexes that must be ignored.
    task automatic apply_setting(setting_t st);
        write_reg(CFG_ORIGIN_X, st.ox);
        write_reg(3'd6, $urandom);
        write_reg(CFG_ORIGIN_Y, st.oy);
        write_reg(CFG_ORIGIN_Z, st.oz);
        write_reg(CFG_RADIUS, st.rad);
        write_reg(CFG_FLOOR, st.flr);
        write_reg(3'd7, $urandom);
        write_reg(CFG_TOLERANCE, st.tol);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] small_signed(int span);
        return 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic setting_t random_setting();
        setting_t st;
        st.ox = ($urandom_range(0, 4) == 0) ? $urandom : small_signed(131072);
        st.oy = ($urandom_range(0, 4) == 0) ? $urandom : small_signed(131072);
        st.oz = ($urandom_range(0, 4) == 0) ? $urandom : small_signed(131072);
        case ($urandom_range(0, 9))
            0: st.rad = $urandom;
            1: st.rad = $urandom_range(0, 3);
            default: st.rad = $urandom_range(1, 8) * 65536 + $urandom_range(0, 65535);
        endcase
        st.flr = ($urandom_range(0, 3) == 0) ? $urandom : small_signed(131072);
        case ($urandom_range(0, 3))
            0: st.tol = $urandom;
            1: st.tol = small_signed(65536);
            default: st.tol = 32'd66;
        endcase
        return st;
    endfunction

    // Endpoint coordinate: mostly near the cylinder, sometimes anywhere.
    function automatic logic [31:0] random_coord(int span);
        case ($urandom_range(0, 9))
            7, 8: return $urandom;
            9: begin
                case ($urandom_range(0, 4))
                    0: return 32'd0;
                    1: return MAXV;
                    2: return MINV;
                    3: return 32'hffffffff;
                    default: return 32'd1;
                endcase
            end
            default: return small_signed(span);
        endcase
    endfunction

    // Stimulus: reset, the directed table, then random phases.
    initial begin
        setting_t st;
        hit_t     typed_hit;
        int       cur_sel;
        int       span;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_end_x = '0;
        s_end_y = '0;
        s_end_z = '0;
        s_last_ray = 1'b0;
        error_count = 0;
        burst_left = 0;
        reg_ox = '0;
        reg_oy = '0;
        reg_oz = '0;
        reg_radius = 31'(1 << FRAC_BITS_DEF);
        reg_floor = '0;
        reg_tol = 32'sd66;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur_sel = 0;
        foreach (dir_rows[i]) begin
            if (int'(dir_rows[i].sel) != cur_sel) begin
                drain_pipeline();
                cur_sel = dir_rows[i].sel;
                apply_setting(dir_settings[cur_sel]);
            end
            typed_hit = '{dir_rows[i].kx, dir_rows[i].ky, dir_rows[i].kz,
                          dir_rows[i].kk, dir_rows[i].last};
            send_ray(dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].ez, dir_rows[i].last,
                     dir_rows[i].typed, typed_hit);
            pace_sender();
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_pipeline();
            st = random_setting();
            apply_setting(st);
            span = (reg_radius > 31'd50000000) ? 200000000 : 3 * int'(reg_radius) + 65536;
            for (int k = 0; k < PHASE_RAYS; k++) begin
                send_ray(random_coord(span), random_coord(span), random_coord(span),
                         1'($urandom), 1'b0, '0);
                pace_sender();
            end
        end

        drain_pipeline();
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Receiver stall pattern, result checking and watchdog.
    always @(posedge aclk) begin
        hit_t exp_hit;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_cycle <= 0;
            rx_mode <= 0;
            idle_cycles <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 256 == 255) rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 9) < 3);
                default: m_ready <= (rx_cycle % 5 != 0);
            endcase

            if (m_valid && m_ready) begin
                if (pending_hits.size() == 0) begin
                    $display("%0t: result with nothing pending: x %h y %h z %h kind %0d",
                             $time, m_hit_x, m_hit_y, m_hit_z, m_hit_kind);
                    error_count++;
                end else begin
                    exp_hit = pending_hits.pop_front();
                    if (m_hit_x !== exp_hit.x) begin
                        $display("%0t: hit_x expected %h actual %h", $time, exp_hit.x, m_hit_x);
                        error_count++;
                    end
                    if (m_hit_y !== exp_hit.y) begin
                        $display("%0t: hit_y expected %h actual %h", $time, exp_hit.y, m_hit_y);
                        error_count++;
                    end
                    if (m_hit_z !== exp_hit.z) begin
                        $display("%0t: hit_z expected %h actual %h", $time, exp_hit.z, m_hit_z);
                        error_count++;
                    end
                    if (m_hit_kind !== exp_hit.kind) begin
                        $display("%0t: hit_kind expected %0d actual %0d", $time,
                                 exp_hit.kind, m_hit_kind);
                        error_count++;
                    end
                    if (m_last_out !== exp_hit.last) begin
                        $display("%0t: last_out expected %0d actual %0d", $time,
                                 exp_hit.last, m_last_out);
                        error_count++;
                    end
                end
            end

            // A long stretch with no transaction on either channel means a hang.
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WD_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("testbench NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
